FILE: src/fit_policy_block_allocator_unit_defines.svh
// Assertion macros for the bound assertion checker in src/fpba_checker.sv.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FPBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/fpba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    localparam int SLOT_BITS   = 4;
    localparam int AMOUNT_BITS = 16;
    localparam int INDEX_BITS  = 4;
    localparam int REMAIN_BITS = 16;

    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 24;
    localparam int CFG_DATA_BITS = 5;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    typedef enum logic {
        REG_POLICY      = 1'b0,
        REG_BLOCK_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic    clear;
        logic    en;
        policy_t policy;
    } scan_ctl_t;

endpackage

`default_nettype wire

FILE: src/fit_policy_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Fit-policy block allocator. A load beat (s_tuser = 0) writes the free size of block
// slot and returns nothing. A request beat (s_tuser = 1) scans blocks 0 to
// min(block_count, NUM_BLOCKS) - 1 and takes the lowest-index, smallest or largest fitting
// block for first, best or worst fit (policy code 3 acts as first fit), subtracts the
// request and returns one beat with m_tuser = granted. A request holds s_tready low
// through the scan state (skipped when no block is scanned), the drain state and the
// write-back state: the size table has one read port and is read one block a cycle into
// a single compare unit, the drain state makes the last compare and the update state
// writes back. The write-back repeats while an earlier result still waits unaccepted in
// the output register. Once the write-back is done the next beat is taken even if its
// result waits. The table reads as zero after reset through per-block valid bits; there
// is no clearing pass.
module fit_policy_block_allocator_unit #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [3:0] slot, [19:4] amount, [23:20] zero
    input  wire logic [fpba_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // [0] mode
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [3:0] block_index, [19:4] remaining, [23:20] zero
    output logic      [fpba_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // [0] granted
    output logic                                      m_tuser,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
    localparam int PX_W  = (IDX_W > INDEX_BITS) ? IDX_W : INDEX_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    policy_t                  policy_reg;
    logic [CFG_DATA_BITS-1:0] block_count_reg;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic [AMOUNT_BITS-1:0] amount_reg, amount_next;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    logic [SLOT_BITS-1:0]   in_slot;
    logic [AMOUNT_BITS-1:0] in_amount;
    logic                   in_accept;
    logic                   in_load;
    logic                   in_req;
    logic [CNT_W-1:0]       limit_calc;
    logic                   out_free;
    logic                   commit;

    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [SIZE_BITS-1:0] tbl_wdata;
    logic [IDX_W-1:0]     tbl_raddr;
    logic [SIZE_BITS-1:0] tbl_rdata;

    scan_ctl_t            scan_ctl;
    logic                 scan_found;
    logic [IDX_W-1:0]     scan_pick;
    logic [SIZE_BITS-1:0] scan_best;
    logic [CMP_W-1:0]     left_ext;
    logic [PX_W-1:0]      pick_ext;

    assign in_slot   = s_tdata[SLOT_BITS-1:0];
    assign in_amount = s_tdata[SLOT_BITS +: AMOUNT_BITS];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_load   = in_accept && (mode_t'(s_tuser) == MODE_LOAD);
    assign in_req    = in_accept && (mode_t'(s_tuser) == MODE_REQUEST);

    // Saturate the scan length to the table depth.
    assign limit_calc = (int'(block_count_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                              : CNT_W'(block_count_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_UPDATE) && out_free;
    assign left_ext = CMP_W'(scan_best) - CMP_W'(amount_reg);
    assign pick_ext = PX_W'(scan_pick);

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg      <= POL_FIRST;
            block_count_reg <= CFG_DATA_BITS'(16);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_POLICY:      policy_reg      <= policy_t'(cfg_wdata[1:0]);
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        limit_next  = limit_reg;
        amount_next = amount_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    amount_next = in_amount;
                    limit_next  = limit_calc;
                    cnt_next    = '0;
                    state_next  = (limit_calc == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == limit_reg - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
        end
        cnt_reg    <= cnt_next;
        limit_reg  <= limit_next;
        amount_reg <= amount_next;
        rd_idx_reg <= tbl_raddr;
    end

    // Table port: loads write from the input beat, grants write back the reduced size.
    assign tbl_raddr = cnt_reg[IDX_W-1:0];

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = IDX_W'(in_slot);
        tbl_wdata = SIZE_BITS'(in_amount);
        if (commit) begin
            tbl_we    = scan_found;
            tbl_waddr = scan_pick;
            tbl_wdata = left_ext[SIZE_BITS-1:0];
        end else if (in_load) begin
            tbl_we = (int'(in_slot) < NUM_BLOCKS);
        end
    end

    fpba_table #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (tbl_wdata),
        .raddr   (tbl_raddr),
        .rdata   (tbl_rdata)
    );

    assign scan_ctl.clear  = in_req;
    assign scan_ctl.en     = rd_vld_reg;
    assign scan_ctl.policy = policy_reg;

    fpba_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .size    (tbl_rdata),
        .idx     (rd_idx_reg),
        .amount  (amount_reg),
        .found   (scan_found),
        .pick    (scan_pick),
        .best    (scan_best)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (commit) begin
            m_tuser_reg <= scan_found;
            if (scan_found) begin
                m_tdata_reg <= {{(M_TDATA_BITS - INDEX_BITS - REMAIN_BITS){1'b0}},
                                left_ext[REMAIN_BITS-1:0],
                                pick_ext[INDEX_BITS-1:0]};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: src/fpba_table.sv
`timescale 1ns / 1ps
`default_nettype none

module fpba_table #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 we,
    input  wire logic [IDX_W-1:0]     waddr,
    input  wire logic [SIZE_BITS-1:0] wdata,
    input  wire logic [IDX_W-1:0]     raddr,
    output logic      [SIZE_BITS-1:0] rdata
);
    import fpba_pkg::*;

    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [SIZE_BITS-1:0]  mem_q_reg;
    logic                  vld_q_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
    end

    // Entries never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            vld_q_reg <= valid_reg[raddr];
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

`default_nettype wire

FILE: src/fpba_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module fpba_scan #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS,
    parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fpba_pkg::scan_ctl_t               ctl,
    input  wire logic [SIZE_BITS-1:0]              size,
    input  wire logic [IDX_W-1:0]                  idx,
    input  wire logic [fpba_pkg::AMOUNT_BITS-1:0]  amount,
    output logic                                   found,
    output logic      [IDX_W-1:0]                  pick,
    output logic      [SIZE_BITS-1:0]              best
);
    import fpba_pkg::*;

    localparam int CMP_W = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;

    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic                 fits;
    logic                 take;

    assign fits = CMP_W'(size) >= CMP_W'(amount);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (ctl.policy == POL_BEST) begin
                take = size < best_reg;
            end else if (ctl.policy == POL_WORST) begin
                take = size > best_reg;
            end
        end
    end

    always_comb begin
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (ctl.en && take) begin
            found_next = 1'b1;
            pick_next  = idx;
            best_next  = size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign found = found_reg;
    assign pick  = pick_reg;
    assign best  = best_reg;

endmodule

`default_nettype wire

FILE: src/fpba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fit_policy_block_allocator_unit_defines.svh"

module fpba_assertions (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fpba_pkg::M_TDATA_BITS-1:0] m_tdata,
    input wire logic                              m_tuser
);
    import fpba_pkg::*;

    // A refused result keeps its beat.
    `FPBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A refused request reports index and size as zero.
    `FPBA_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)

    // A request beat occupies the scan, so the next cycle takes nothing.
    `FPBA_ASSERT_NEXT(a_req_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready)

    // A load beat leaves the input ready again in the next cycle.
    `FPBA_ASSERT_NEXT(a_load_fast, aclk, aresetn, s_tvalid && s_tready && !s_tuser, s_tready)

endmodule

bind fit_policy_block_allocator_unit fpba_assertions u_fpba_checker (.*);

`default_nettype wire

FILE: verif/fpba_checker.sv
`timescale 1ns / 1ps

module fpba_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [fpba_pkg::S_TDATA_BITS-1:0]    s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [fpba_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [fpba_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output int                                   fail_count,
    output int                                   grants_owed,
    output int                                   n_granted,
    output int                                   n_refused
);
    import fpba_pkg::*;

    localparam int NBLK = DEF_NUM_BLOCKS;

    typedef struct packed {
        logic                   granted;
        logic [INDEX_BITS-1:0]  index;
        logic [REMAIN_BITS-1:0] left;
    } alloc_t;

    logic [DEF_SIZE_BITS-1:0] free_size [NBLK];
    logic [1:0]               fit_pol;
    logic [4:0]               blk_count;
    alloc_t                   owed_q [$];
    int                       errs;
    int                       granted_cnt;
    int                       refused_cnt;

    // Pick a block under the current policy and carve the request out of it.
    function automatic alloc_t carve(input logic [AMOUNT_BITS-1:0] want);
        alloc_t r;
        int     lim;
        int     pick;
        bit     found;
        bit     stop;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        stop  = 1'b0;
        lim   = (blk_count > NBLK) ? NBLK : int'(blk_count);
        for (int j = 0; j < lim; j++) begin
            if (!stop && free_size[j] >= want) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = j;
                    // policy code three falls back to first fit
                    if (fit_pol != POL_BEST && fit_pol != POL_WORST) stop = 1'b1;
                end else if (fit_pol == POL_BEST && free_size[j] < free_size[pick]) begin
                    pick = j;
                end else if (fit_pol == POL_WORST && free_size[j] > free_size[pick]) begin
                    pick = j;
                end
            end
        end
        if (found) begin
            free_size[pick] = free_size[pick] - want;
            r.granted = 1'b1;
            r.index   = pick[INDEX_BITS-1:0];
            r.left    = free_size[pick];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_t got;
        alloc_t want;
        if (!aresetn) begin
            for (int i = 0; i < NBLK; i++) free_size[i] = '0;
            fit_pol     = POL_FIRST;
            blk_count   = 5'd16;
            errs        = 0;
            granted_cnt = 0;
            refused_cnt = 0;
            owed_q.delete();
            fail_count  <= 0;
            grants_owed <= 0;
            n_granted   <= 0;
            n_refused   <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_POLICY) fit_pol = cfg_wdata[1:0];
                else blk_count = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[3:0], m_tdata[19:4]};
                if (owed_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result beat granted=%0d index=%0d remaining=%0d",
                             $time, got.granted, got.index, got.left);
                end else begin
                    want = owed_q.pop_front();
                    if (got.granted !== want.granted) begin
                        errs++;
                        $display("%0t: granted expected %0d got %0d",
                                 $time, want.granted, got.granted);
                    end
                    if (got.index !== want.index) begin
                        errs++;
                        $display("%0t: block_index expected %0d got %0d",
                                 $time, want.index, got.index);
                    end
                    if (got.left !== want.left) begin
                        errs++;
                        $display("%0t: remaining expected %0d got %0d",
                                 $time, want.left, got.left);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_LOAD) begin
                    free_size[s_tdata[3:0]] = s_tdata[19:4];
                end else begin
                    want = carve(s_tdata[19:4]);
                    owed_q.push_back(want);
                    if (want.granted) granted_cnt++;
                    else refused_cnt++;
                end
            end
            fail_count  <= errs;
            grants_owed <= owed_q.size();
            n_granted   <= granted_cnt;
            n_refused   <= refused_cnt;
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fpba_pkg::*;

    localparam int TARGET_BEATS = 1850;
    localparam int QUIET_LIMIT  = 2000;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_BITS-1:0]    s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]    m_tdata;
    logic                       m_tuser;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;

    int fail_count;
    int grants_owed;
    int n_granted;
    int n_refused;
    int beats_sent = 0;
    int phases     = 0;
    int quiet      = 0;
    bit calm       = 1'b0;

    fit_policy_block_allocator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fpba_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .grants_owed (grants_owed),
        .n_granted   (n_granted),
        .n_refused   (n_refused)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 23);
    end

    // End the run if the channels go quiet for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
                if (quiet >= QUIET_LIMIT) begin
                    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic offer_beat(input mode_t mode, input logic [SLOT_BITS-1:0] slot,
                              input logic [AMOUNT_BITS-1:0] amount);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 23) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, amount, slot};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic load_block(input logic [SLOT_BITS-1:0] slot,
                              input logic [AMOUNT_BITS-1:0] size);
        offer_beat(MODE_LOAD, slot, size);
    endtask

    // Slot is don't-care on a request, so scramble it.
    task automatic ask_alloc(input logic [AMOUNT_BITS-1:0] amount);
        offer_beat(MODE_REQUEST, SLOT_BITS'($urandom), amount);
    endtask

    // Hold the sender until every result is back and any load has landed.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (grants_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_BITS-1:0] pol_data,
                              input logic [CFG_DATA_BITS-1:0] cnt_data);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POLICY;
        cfg_wdata <= pol_data;
        @(posedge aclk);
        cfg_index <= REG_BLOCK_COUNT;
        cfg_wdata <= cnt_data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        phases++;
    endtask

    function automatic logic [AMOUNT_BITS-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return AMOUNT_BITS'(256 << $urandom_range(0, 2));  // provoke ties
            4:       return AMOUNT_BITS'($urandom);
            default: return AMOUNT_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [AMOUNT_BITS-1:0] pick_request();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2, 3:    return AMOUNT_BITS'($urandom);
            4, 5, 6: return AMOUNT_BITS'($urandom_range(0, 4095));
            default: return AMOUNT_BITS'($urandom_range(1, 600));
        endcase
    endfunction

    initial begin
        logic [1:0]               pol;
        logic [CFG_DATA_BITS-1:0] cnt;
        int                       cnt_eff;
        int                       n_loads;
        int                       n_reqs;
        int                       roll;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset state: empty table, first fit over all sixteen blocks.
        ask_alloc(16'd0);
        ask_alloc(16'd1);
        load_block(4'd15, 16'hFFFF);
        load_block(4'd3, 16'd100);
        load_block(4'd7, 16'd100);
        load_block(4'd9, 16'd50000);
        load_block(4'd0, 16'd0);
        ask_alloc(16'd100);
        ask_alloc(16'hFFFF);
        ask_alloc(16'd60);

        settle();
        set_config({3'b000, POL_BEST}, 5'd16);
        load_block(4'd5, 16'd300);
        load_block(4'd6, 16'd300);
        load_block(4'd8, 16'd1000);
        ask_alloc(16'd250);
        ask_alloc(16'd1);

        settle();
        set_config({3'b000, POL_WORST}, 5'd16);
        ask_alloc(16'd1);
        ask_alloc(16'hFFFF);

        // Undefined policy code with junk above it, count past the table.
        settle();
        set_config({3'b111, 2'd3}, 5'd31);
        ask_alloc(16'd30);

        settle();
        set_config({3'b000, POL_FIRST}, 5'd0);
        ask_alloc(16'd0);

        settle();
        set_config({3'b000, POL_BEST}, 5'd1);
        ask_alloc(16'd0);
        load_block(4'd0, 16'h00FF);
        ask_alloc(16'h00FF);

        while (beats_sent < TARGET_BEATS) begin
            settle();
            pol = 2'($urandom_range(0, 3));
            case ($urandom_range(9))
                0:       cnt = 5'd0;
                1:       cnt = 5'd1;
                2:       cnt = 5'd16;
                3:       cnt = 5'($urandom_range(17, 31));
                default: cnt = 5'($urandom_range(2, 15));
            endcase
            set_config({3'($urandom), pol}, cnt);
            calm    = (beats_sent >= 700 && beats_sent < 1000);
            cnt_eff = (cnt > 16) ? 16 : int'(cnt);

            n_loads = $urandom_range(1, 12);
            for (int i = 0; i < n_loads; i++) begin
                if (cnt_eff > 0 && $urandom_range(3) != 0)
                    load_block(SLOT_BITS'($urandom_range(0, cnt_eff - 1)), pick_size());
                else
                    load_block(SLOT_BITS'($urandom), pick_size());
            end

            n_reqs = $urandom_range(8, 40);
            for (int i = 0; i < n_reqs; i++) begin
                roll = $urandom_range(99);
                if (roll < 10)
                    offer_beat(mode_t'($urandom_range(1)), SLOT_BITS'($urandom),
                               AMOUNT_BITS'($urandom));
                else if (roll < 22)
                    load_block(SLOT_BITS'($urandom), pick_size());
                else
                    ask_alloc(pick_request());
            end
        end

        settle();
        repeat (20) @(posedge aclk);

        $display("Sent %0d beats over %0d register settings: all policy codes, counts 0..31.",
                 beats_sent, phases);
        $display("Requests granted %0d, refused %0d; mismatches %0d.",
                 n_granted, n_refused, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
